FILE: rtl/core/srmf_pkg.sv
// Shared constants, types and helpers of the separable RGBA minimum filter.
package srmf_pkg;

  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_HEIGHT = 4096;
  localparam int MAX_RADIUS = 7;

  localparam int STORE_ROWS = 2 * MAX_RADIUS;
  localparam int WIN_COLS   = 2 * MAX_RADIUS + 1;
  localparam int WIN_ROWS   = MAX_RADIUS + 1;

  localparam int PIX_W  = 32;
  localparam int COL_W  = 10;
  localparam int ROW_W  = 12;
  localparam int RAD_W  = 3;
  localparam int WREG_W = 11;
  localparam int HREG_W = 13;

  localparam int RS_DEPTH = STORE_ROWS * MAX_WIDTH;
  localparam int RS_AW    = $clog2(RS_DEPTH);
  localparam int CW_DEPTH = WIN_ROWS * WIN_COLS;
  localparam int CW_AW    = $clog2(CW_DEPTH);
  localparam int RSLOT_W  = $clog2(STORE_ROWS);
  localparam int CSLOT_W  = $clog2(WIN_COLS);
  localparam int K_W      = $clog2(WIN_ROWS);
  localparam int CNT_W    = $clog2(WIN_COLS + 1);

  localparam int PADDR_W  = 4;

  // Configuration register indexes
  typedef enum logic [1:0] {
    REG_IMAGE_WIDTH  = 2'd0,
    REG_IMAGE_HEIGHT = 2'd1,
    REG_RADIUS_X     = 2'd2,
    REG_RADIUS_Y     = 2'd3
  } srmf_reg_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_VINIT,
    ST_VSTART,
    ST_VREAD,
    ST_VDRAIN,
    ST_VWRITE,
    ST_RSWR,
    ST_HINIT,
    ST_HSTART,
    ST_HREAD,
    ST_HDRAIN,
    ST_HOUT,
    ST_ADV
  } srmf_state_t;

  typedef struct packed {
    logic accept;
    logic loop_init;
    logic v_start;
    logic v_issue;
    logic v_write;
    logic rs_write;
    logic h_start;
    logic h_issue;
    logic out_load;
    logic next_x;
    logic next_y;
    logic advance;
  } srmf_cmd_t;

  typedef struct packed {
    logic have_rows;
    logic have_cols;
    logic d_zero;
    logic rd_last;
    logic x_last;
    logic y_last;
    logic out_free;
  } srmf_stat_t;

  // Per-byte minimum of two pixels
  function automatic logic [PIX_W-1:0] min_bytes(input logic [PIX_W-1:0] a,
                                                 input logic [PIX_W-1:0] b);
    logic [PIX_W-1:0] r;
    r = '0;
    for (int s = 0; s < PIX_W / 8; s++) begin
      r[s*8 +: 8] = (a[s*8 +: 8] < b[s*8 +: 8]) ? a[s*8 +: 8] : b[s*8 +: 8];
    end
    return r;
  endfunction

endpackage

FILE: rtl/core/srmf_pix_if.sv
// Input pixel channel: valid/ready handshake with four 8-bit bytes.
interface srmf_pix_if;
  logic       valid;
  logic       ready;
  logic [7:0] alpha_in;
  logic [7:0] red_in;
  logic [7:0] green_in;
  logic [7:0] blue_in;

  modport source (output valid, alpha_in, red_in, green_in, blue_in, input ready);
  modport sink   (input valid, alpha_in, red_in, green_in, blue_in, output ready);
endinterface

FILE: rtl/core/srmf_res_if.sv
// Result channel: filtered pixel with its coordinates and end-of-run flag.
interface srmf_res_if;
  logic        valid;
  logic        ready;
  logic [7:0]  alpha_out;
  logic [7:0]  red_out;
  logic [7:0]  green_out;
  logic [7:0]  blue_out;
  logic [9:0]  out_col;
  logic [11:0] out_row;
  logic        run_last;

  modport source (output valid, alpha_out, red_out, green_out, blue_out, out_col, out_row,
                  run_last, input ready);
  modport sink   (input valid, alpha_out, red_out, green_out, blue_out, out_col, out_row,
                  run_last, output ready);
endinterface

FILE: rtl/core/separable_rgba_min_filter_top.sv
// Top level: configuration registers, channel hookup, controller and datapath.
//
// Per-channel minimum filter over a raster stream of RGBA pixels. Pixels enter
// on in_chan (valid/ready) in raster order; each accepted request produces zero
// or more filtered pixels on out_chan, in row then column order, each with its
// out_col and out_row and with run_last set on the final one of the request.
// Configuration is written through the APB port while the stream is idle; any
// write restarts the frame at row 0, column 0.
// Sequence: after accept, a request steps through a loop-init state and then, for
// each vertical minimum it forms, a start state, a read state per stored row
// (up to 2*radius_y) plus a drain state when there are rows to read, and a
// write state; then the row-store write and, when it completes any result, an
// init state and for each result a start, a read per window column (up to
// 2*radius_x+1), a drain and an output state; last the advance state. The single
// read port of each memory sets this: rows are read one per cycle.
// Reset (synchronous, active low) restores the default registers, clears the
// raster position and empties the result register; no memory clearing pass.
// When the receiver stalls, a finished result waits in the output register and
// the controller holds at the next result until the register frees up.
module separable_rgba_min_filter_top (
  input  logic                          clk,
  input  logic                          rst_n,
  srmf_pix_if.sink                      in_chan,
  srmf_res_if.source                    out_chan,
  input  logic                          cfg_psel,
  input  logic                          cfg_penable,
  input  logic                          cfg_pwrite,
  input  logic [srmf_pkg::PADDR_W-1:0]  cfg_paddr,
  input  logic [31:0]                   cfg_pwdata,
  output logic [31:0]                   cfg_prdata,
  output logic                          cfg_pready
);

  logic [srmf_pkg::WREG_W-1:0] image_width_r;
  logic [srmf_pkg::HREG_W-1:0] image_height_r;
  logic [srmf_pkg::RAD_W-1:0]  radius_x_r;
  logic [srmf_pkg::RAD_W-1:0]  radius_y_r;
  logic                        cfg_wr;
  srmf_pkg::srmf_reg_t         cfg_idx;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;
  assign cfg_idx    = srmf_pkg::srmf_reg_t'(cfg_paddr[3:2]);

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      image_width_r  <= srmf_pkg::WREG_W'(1024);
      image_height_r <= srmf_pkg::HREG_W'(1024);
      radius_x_r     <= srmf_pkg::RAD_W'(1);
      radius_y_r     <= srmf_pkg::RAD_W'(1);
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        srmf_pkg::REG_IMAGE_WIDTH:  image_width_r  <= cfg_pwdata[srmf_pkg::WREG_W-1:0];
        srmf_pkg::REG_IMAGE_HEIGHT: image_height_r <= cfg_pwdata[srmf_pkg::HREG_W-1:0];
        srmf_pkg::REG_RADIUS_X:     radius_x_r     <= cfg_pwdata[srmf_pkg::RAD_W-1:0];
        srmf_pkg::REG_RADIUS_Y:     radius_y_r     <= cfg_pwdata[srmf_pkg::RAD_W-1:0];
        default: ;
      endcase
    end
  end

  // Read back configuration registers
  always_comb begin
    unique case (cfg_idx)
      srmf_pkg::REG_IMAGE_WIDTH:  cfg_prdata = 32'(image_width_r);
      srmf_pkg::REG_IMAGE_HEIGHT: cfg_prdata = 32'(image_height_r);
      srmf_pkg::REG_RADIUS_X:     cfg_prdata = 32'(radius_x_r);
      srmf_pkg::REG_RADIUS_Y:     cfg_prdata = 32'(radius_y_r);
      default:                    cfg_prdata = '0;
    endcase
  end

  srmf_pkg::srmf_cmd_t  cmd;
  srmf_pkg::srmf_stat_t stat;
  logic [srmf_pkg::PIX_W-1:0] out_pix;

  srmf_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_chan.valid),
    .in_ready (in_chan.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  srmf_dp u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_restart  (cfg_wr),
    .image_width  (image_width_r),
    .image_height (image_height_r),
    .radius_x     (radius_x_r),
    .radius_y     (radius_y_r),
    .in_pix       ({in_chan.blue_in, in_chan.green_in, in_chan.red_in, in_chan.alpha_in}),
    .cmd          (cmd),
    .stat         (stat),
    .out_ready    (out_chan.ready),
    .out_valid    (out_chan.valid),
    .out_pix      (out_pix),
    .out_col      (out_chan.out_col),
    .out_row      (out_chan.out_row),
    .run_last     (out_chan.run_last)
  );

  assign out_chan.alpha_out = out_pix[7:0];
  assign out_chan.red_out   = out_pix[15:8];
  assign out_chan.green_out = out_pix[23:16];
  assign out_chan.blue_out  = out_pix[31:24];

endmodule

FILE: rtl/core/srmf_ctrl.sv
// Controller state machine sequencing vertical, store and horizontal phases.
module srmf_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  srmf_pkg::srmf_stat_t stat,
  output srmf_pkg::srmf_cmd_t  cmd
);

  srmf_pkg::srmf_state_t state_r, state_nxt;

  // Hold state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= srmf_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      srmf_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_nxt  = srmf_pkg::ST_VINIT;
        end
      end
      srmf_pkg::ST_VINIT: begin
        cmd.loop_init = 1'b1;
        state_nxt = stat.have_rows ? srmf_pkg::ST_VSTART : srmf_pkg::ST_RSWR;
      end
      srmf_pkg::ST_VSTART: begin
        cmd.v_start = 1'b1;
        state_nxt = stat.d_zero ? srmf_pkg::ST_VWRITE : srmf_pkg::ST_VREAD;
      end
      srmf_pkg::ST_VREAD: begin
        cmd.v_issue = 1'b1;
        if (stat.rd_last) state_nxt = srmf_pkg::ST_VDRAIN;
      end
      srmf_pkg::ST_VDRAIN: begin
        state_nxt = srmf_pkg::ST_VWRITE;
      end
      srmf_pkg::ST_VWRITE: begin
        cmd.v_write = 1'b1;
        if (stat.y_last) begin
          state_nxt = srmf_pkg::ST_RSWR;
        end else begin
          cmd.next_y = 1'b1;
          state_nxt  = srmf_pkg::ST_VSTART;
        end
      end
      srmf_pkg::ST_RSWR: begin
        cmd.rs_write = 1'b1;
        state_nxt = (stat.have_rows && stat.have_cols) ? srmf_pkg::ST_HINIT
                                                       : srmf_pkg::ST_ADV;
      end
      srmf_pkg::ST_HINIT: begin
        cmd.loop_init = 1'b1;
        state_nxt = srmf_pkg::ST_HSTART;
      end
      srmf_pkg::ST_HSTART: begin
        cmd.h_start = 1'b1;
        state_nxt = srmf_pkg::ST_HREAD;
      end
      srmf_pkg::ST_HREAD: begin
        cmd.h_issue = 1'b1;
        if (stat.rd_last) state_nxt = srmf_pkg::ST_HDRAIN;
      end
      srmf_pkg::ST_HDRAIN: begin
        state_nxt = srmf_pkg::ST_HOUT;
      end
      srmf_pkg::ST_HOUT: begin
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          priority if (!stat.x_last) begin
            cmd.next_x = 1'b1;
            state_nxt  = srmf_pkg::ST_HSTART;
          end else if (!stat.y_last) begin
            cmd.next_y = 1'b1;
            state_nxt  = srmf_pkg::ST_HSTART;
          end else begin
            state_nxt = srmf_pkg::ST_ADV;
          end
        end
      end
      srmf_pkg::ST_ADV: begin
        cmd.advance = 1'b1;
        state_nxt = srmf_pkg::ST_IDLE;
      end
      default: begin
        state_nxt = srmf_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

FILE: rtl/core/srmf_dp.sv
// Datapath: raster counters, row store, column-minimum window and result register.
module srmf_dp (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_restart,
  input  logic [srmf_pkg::WREG_W-1:0]         image_width,
  input  logic [srmf_pkg::HREG_W-1:0]         image_height,
  input  logic [srmf_pkg::RAD_W-1:0]          radius_x,
  input  logic [srmf_pkg::RAD_W-1:0]          radius_y,
  input  logic [srmf_pkg::PIX_W-1:0]          in_pix,
  input  srmf_pkg::srmf_cmd_t                 cmd,
  output srmf_pkg::srmf_stat_t                stat,
  input  logic                                out_ready,
  output logic                                out_valid,
  output logic [srmf_pkg::PIX_W-1:0]          out_pix,
  output logic [srmf_pkg::COL_W-1:0]          out_col,
  output logic [srmf_pkg::ROW_W-1:0]          out_row,
  output logic                                run_last
);

  localparam int COL_W   = srmf_pkg::COL_W;
  localparam int ROW_W   = srmf_pkg::ROW_W;
  localparam int RSLOT_W = srmf_pkg::RSLOT_W;
  localparam int CSLOT_W = srmf_pkg::CSLOT_W;
  localparam int CNT_W   = srmf_pkg::CNT_W;
  localparam int K_W     = srmf_pkg::K_W;
  localparam int RS_AW   = srmf_pkg::RS_AW;
  localparam int CW_AW   = srmf_pkg::CW_AW;
  localparam int PIX_W   = srmf_pkg::PIX_W;

  // Effective geometry
  logic [COL_W-1:0]         w_m1;
  logic [ROW_W-1:0]         h_m1;
  logic [srmf_pkg::RAD_W-1:0] rx, ry;

  always_comb begin
    priority if (image_width == '0) begin
      w_m1 = '0;
    end else if (image_width > srmf_pkg::WREG_W'(srmf_pkg::MAX_WIDTH)) begin
      w_m1 = COL_W'(srmf_pkg::MAX_WIDTH - 1);
    end else begin
      w_m1 = COL_W'(image_width - 1'b1);
    end
    priority if (image_height == '0) begin
      h_m1 = '0;
    end else if (image_height > srmf_pkg::HREG_W'(srmf_pkg::MAX_HEIGHT)) begin
      h_m1 = ROW_W'(srmf_pkg::MAX_HEIGHT - 1);
    end else begin
      h_m1 = ROW_W'(image_height - 1'b1);
    end
    rx = (radius_x > srmf_pkg::RAD_W'(srmf_pkg::MAX_RADIUS)) ?
         srmf_pkg::RAD_W'(srmf_pkg::MAX_RADIUS) : radius_x;
    ry = (radius_y > srmf_pkg::RAD_W'(srmf_pkg::MAX_RADIUS)) ?
         srmf_pkg::RAD_W'(srmf_pkg::MAX_RADIUS) : radius_y;
  end

  // Raster position and its ring slots
  logic [COL_W-1:0]   col_cnt_r;
  logic [ROW_W-1:0]   row_cnt_r;
  logic [CSLOT_W-1:0] cmod_r;
  logic [RSLOT_W-1:0] rmod_r;

  // Request latched at accept
  logic [PIX_W-1:0]   pix_r;
  logic [COL_W-1:0]   cur_c_r;
  logic [ROW_W-1:0]   cur_r_r;
  logic [CSLOT_W-1:0] cur_cslot_r;
  logic [RSLOT_W-1:0] cur_rslot_r;

  // Loop registers
  logic [ROW_W-1:0]   y_r;
  logic [COL_W-1:0]   x_r;
  logic [K_W-1:0]     k_r;
  logic [CNT_W-1:0]   rd_cnt_r;
  logic [RSLOT_W-1:0] rr_slot_r;
  logic [CSLOT_W-1:0] xx_slot_r;
  logic [PIX_W-1:0]   acc_r;
  logic               rd_valid_r;
  logic               rd_h_r;
  logic [PIX_W-1:0]   rs_q_r;
  logic [PIX_W-1:0]   cw_q_r;

  // Step geometry
  logic             last_row, last_col;
  logic [ROW_W-1:0] y0, y1, v_lo;
  logic [COL_W-1:0] x0, x1, h_lo, h_hi;
  logic [COL_W:0]   x_plus;
  logic [CNT_W-1:0] v_d, h_d, h_cnt;
  logic [RSLOT_W:0] v_slot0;
  logic [CSLOT_W:0] h_slot0;

  always_comb begin
    last_row = (cur_r_r == h_m1);
    last_col = (cur_c_r == w_m1);
    y0 = (cur_r_r >= ROW_W'(ry)) ? cur_r_r - ROW_W'(ry) : '0;
    y1 = last_row ? cur_r_r : y0;
    x0 = (cur_c_r >= COL_W'(rx)) ? cur_c_r - COL_W'(rx) : '0;
    x1 = last_col ? cur_c_r : x0;
    // vertical rows lo..r-1 for output row y
    v_lo = (y_r >= ROW_W'(ry)) ? y_r - ROW_W'(ry) : '0;
    v_d  = CNT_W'(cur_r_r - v_lo);
    v_slot0 = (RSLOT_W+1)'(cur_rslot_r)
            + ((cur_rslot_r >= RSLOT_W'(v_d)) ? '0 : (RSLOT_W+1)'(srmf_pkg::STORE_ROWS))
            - (RSLOT_W+1)'(v_d);
    // horizontal columns lo..hi for output column x
    h_lo   = (x_r >= COL_W'(rx)) ? x_r - COL_W'(rx) : '0;
    x_plus = (COL_W+1)'(x_r) + (COL_W+1)'(rx);
    h_hi   = (x_plus > (COL_W+1)'(w_m1)) ? w_m1 : COL_W'(x_plus);
    h_cnt  = CNT_W'(h_hi - h_lo + 1'b1);
    h_d    = CNT_W'(cur_c_r - h_lo);
    h_slot0 = (CSLOT_W+1)'(cur_cslot_r)
            + ((cur_cslot_r >= CSLOT_W'(h_d)) ? '0 : (CSLOT_W+1)'(srmf_pkg::WIN_COLS))
            - (CSLOT_W+1)'(h_d);
  end

  assign stat.have_rows = last_row || (cur_r_r >= ROW_W'(ry));
  assign stat.have_cols = last_col || (cur_c_r >= COL_W'(rx));
  assign stat.d_zero    = (v_d == '0);
  assign stat.rd_last   = (rd_cnt_r == CNT_W'(1));
  assign stat.x_last    = (x_r == x1);
  assign stat.y_last    = (y_r == y1);
  assign stat.out_free  = !out_valid || out_ready;

  // Advance raster position, restart on configuration write
  always_ff @(posedge clk) begin
    if (!rst_n || cfg_restart) begin
      col_cnt_r <= '0;
      row_cnt_r <= '0;
      cmod_r    <= '0;
      rmod_r    <= '0;
    end else if (cmd.advance) begin
      if (last_col) begin
        col_cnt_r <= '0;
        cmod_r    <= '0;
        row_cnt_r <= last_row ? '0 : cur_r_r + 1'b1;
        if (last_row || cur_rslot_r == RSLOT_W'(srmf_pkg::STORE_ROWS - 1)) begin
          rmod_r <= '0;
        end else begin
          rmod_r <= cur_rslot_r + 1'b1;
        end
      end else begin
        col_cnt_r <= cur_c_r + 1'b1;
        cmod_r    <= (cur_cslot_r == CSLOT_W'(srmf_pkg::WIN_COLS - 1)) ? '0
                                                                         : cur_cslot_r + 1'b1;
        row_cnt_r <= cur_r_r;
        rmod_r    <= cur_rslot_r;
      end
    end
  end

  // Latch request
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      pix_r <= in_pix;
      if (col_cnt_r <= w_m1) begin
        cur_c_r     <= col_cnt_r;
        cur_cslot_r <= cmod_r;
      end else begin
        cur_c_r     <= '0;
        cur_cslot_r <= '0;
      end
      if (row_cnt_r <= h_m1) begin
        cur_r_r     <= row_cnt_r;
        cur_rslot_r <= rmod_r;
      end else begin
        cur_r_r     <= '0;
        cur_rslot_r <= '0;
      end
    end
  end

  // Loop counters and read sequencing
  always_ff @(posedge clk) begin
    if (cmd.loop_init) begin
      y_r <= y0;
      k_r <= '0;
      x_r <= x0;
    end else if (cmd.next_x) begin
      x_r <= x_r + 1'b1;
    end else if (cmd.next_y) begin
      y_r <= y_r + 1'b1;
      k_r <= k_r + 1'b1;
      x_r <= x0;
    end

    if (cmd.v_start) begin
      rd_cnt_r  <= v_d;
      rr_slot_r <= RSLOT_W'(v_slot0);
    end else if (cmd.h_start) begin
      rd_cnt_r  <= h_cnt;
      xx_slot_r <= CSLOT_W'(h_slot0);
    end else if (cmd.v_issue) begin
      rd_cnt_r  <= rd_cnt_r - 1'b1;
      rr_slot_r <= (rr_slot_r == RSLOT_W'(srmf_pkg::STORE_ROWS - 1)) ? '0
                                                                      : rr_slot_r + 1'b1;
    end else if (cmd.h_issue) begin
      rd_cnt_r  <= rd_cnt_r - 1'b1;
      xx_slot_r <= (xx_slot_r == CSLOT_W'(srmf_pkg::WIN_COLS - 1)) ? '0
                                                                    : xx_slot_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_valid_r <= 1'b0;
      rd_h_r     <= 1'b0;
    end else begin
      rd_valid_r <= cmd.v_issue || cmd.h_issue;
      rd_h_r     <= cmd.h_issue;
    end
  end

  // Accumulate minimum from the registered data of each read
  always_ff @(posedge clk) begin
    if (cmd.v_start) begin
      acc_r <= pix_r;
    end else if (cmd.h_start) begin
      acc_r <= '1;
    end else if (rd_valid_r) begin
      acc_r <= srmf_pkg::min_bytes(acc_r, rd_h_r ? cw_q_r : rs_q_r);
    end
  end

  // Row store memory
  logic [PIX_W-1:0] row_store [srmf_pkg::RS_DEPTH];
  logic [RS_AW-1:0] rs_raddr, rs_waddr;

  assign rs_raddr = RS_AW'(RS_AW'(rr_slot_r) * RS_AW'(srmf_pkg::MAX_WIDTH)) + RS_AW'(cur_c_r);
  assign rs_waddr = RS_AW'(RS_AW'(cur_rslot_r) * RS_AW'(srmf_pkg::MAX_WIDTH))
                  + RS_AW'(cur_c_r);

  always_ff @(posedge clk) begin
    if (cmd.rs_write) begin
      row_store[rs_waddr] <= pix_r;
    end
    rs_q_r <= row_store[rs_raddr];
  end

  // Column-minimum window memory
  logic [PIX_W-1:0] col_win [srmf_pkg::CW_DEPTH];
  logic [CW_AW-1:0] cw_raddr, cw_waddr;

  assign cw_raddr = CW_AW'(CW_AW'(k_r) * CW_AW'(srmf_pkg::WIN_COLS)) + CW_AW'(xx_slot_r);
  assign cw_waddr = CW_AW'(CW_AW'(k_r) * CW_AW'(srmf_pkg::WIN_COLS)) + CW_AW'(cur_cslot_r);

  always_ff @(posedge clk) begin
    if (cmd.v_write) begin
      col_win[cw_waddr] <= acc_r;
    end
    cw_q_r <= col_win[cw_raddr];
  end

  // Result register
  logic out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= cmd.out_load || (out_valid_r && !out_ready);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_pix  <= acc_r;
      out_col  <= x_r;
      out_row  <= y_r;
      run_last <= (x_r == x1) && (y_r == y1);
    end
  end

  assign out_valid = out_valid_r;

endmodule

FILE: rtl/core/srmf_checker.sv
// Port-level checker for the minimum filter top level, with its bind.
module srmf_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [9:0]  out_col,
  input logic [11:0] out_row,
  input logic        run_last
);

  // Reset empties the result register
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // Stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_col) && $stable(out_row)
                                && $stable(run_last))
    else $error("stalled result changed");

  // One request at a time: input closes right after an accept
  a_one_req: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input open right after accept");

  // New results only appear while the input is closed
  a_load_busy: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid ##1 out_valid |-> $past(!in_ready))
    else $error("result appeared while idle");

endmodule

bind separable_rgba_min_filter_top srmf_checker u_srmf_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_chan.valid),
  .in_ready  (in_chan.ready),
  .out_valid (out_chan.valid),
  .out_ready (out_chan.ready),
  .out_col   (out_chan.out_col),
  .out_row   (out_chan.out_row),
  .run_last  (out_chan.run_last)
);
